/* rtl/core/bcs_pkg.sv */
// Shared types and constants for the RGB brightness, contrast and saturation block.
// Depends on nothing; every other file in rtl/core imports it.
package bcs_pkg;

  localparam int ChanW   = 8;
  localparam int OffsetW = 17;
  localparam int GainW   = 10;
  localparam int Gain2W  = 2 * GainW;
  localparam int LumaW   = 24;
  localparam int IndexW  = 2;
  localparam int CfgW    = OffsetW;

  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  localparam logic [OffsetW-1:0] OFFSET_RESET = '0;
  localparam logic [GainW-1:0]   GAIN_RESET   = 10'd256;

  typedef enum logic [IndexW-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_SATURATION = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic             frame_end_in;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             frame_end_out;
  } result_t;

endpackage

/* rtl/core/rgb_brightness_contrast_saturation_top.sv */
// Top level of the RGB brightness, contrast and saturation adjuster.
// Instantiates three bcs_lane copies and bcs_merge; depends on bcs_pkg.
//
// Usage:
// An item is one RGB pixel with an end-of-frame mark on pixel. It is taken at
// a rising edge where start is high and busy is low. Busy is a registered copy
// of rst and falls in the cycle after rst falls; then an item can enter every clock.
// Each result is on result for one cycle with done high, once the item has passed the
// registers bright and ch in each lane and g16 and result in bcs_merge.
// Results keep the order of the items.
// The receiver cannot stall; results are never held back.
// Throughput is one item per cycle through the four-stage pipeline:
// brightness, contrast (one multiplier per lane), luma, and saturation
// (one multiplier per channel).
// Registers are written on the cfg channel, which is always ready. Index 0
// is the brightness offset, 1 the contrast gain, 2 the saturation gain;
// other indexes are ignored. The squared contrast gain is registered from the
// stored contrast gain, so it is updated in the cycle after a write.
// Reset clears the pipeline and restores offset 0 and unity gains.
module rgb_brightness_contrast_saturation_top
  import bcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pixel_t            pixel,
  output result_t           result,
  output logic              done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [CfgW-1:0]   cfg_data
);

  logic                      accept;
  logic                      cfg_write;
  logic signed [OffsetW-1:0] brightness_offset;
  logic [GainW-1:0]          contrast_gain;
  logic [GainW-1:0]          saturation_gain;
  logic [Gain2W-1:0]         c2;
  logic                      valid1;
  logic                      valid2;
  logic                      frame_end1;
  logic                      frame_end2;
  logic [ChanW-1:0]          ch [3];
  logic [ChanW-1:0]          lane_in [3];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_offset <= OFFSET_RESET;
      contrast_gain     <= GAIN_RESET;
      saturation_gain   <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness_offset <= cfg_data;
        REG_CONTRAST:   contrast_gain     <= cfg_data[GainW-1:0];
        REG_SATURATION: saturation_gain   <= cfg_data[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    c2 <= Gain2W'(contrast_gain) * Gain2W'(contrast_gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    frame_end1 <= pixel.frame_end_in;
    frame_end2 <= frame_end1;
  end

  assign lane_in[0] = pixel.red_in;
  assign lane_in[1] = pixel.green_in;
  assign lane_in[2] = pixel.blue_in;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    bcs_lane u_lane (
      .clk    (clk),
      .p      (lane_in[i]),
      .offset (brightness_offset),
      .c2     (c2),
      .ch     (ch[i])
    );
  end

  bcs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid2),
    .red       (ch[0]),
    .green     (ch[1]),
    .blue      (ch[2]),
    .frame_end (frame_end2),
    .sat_gain  (saturation_gain),
    .result    (result),
    .done      (done)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("item accepted without a result four cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result strobe without a matching item");

  a_busy_reset: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("block not held off after reset");

endmodule

/* rtl/core/bcs_lane.sv */
// One color lane: brightness offset and clamp, then contrast scaling and clamp.
// Two register stages. Depends on bcs_pkg.
module bcs_lane
  import bcs_pkg::*;
(
  input  logic                      clk,
  input  logic [ChanW-1:0]          p,
  input  logic signed [OffsetW-1:0] offset,
  input  logic [Gain2W-1:0]         c2,
  output logic [ChanW-1:0]          ch
);

  logic signed [18:0] bv;
  logic [ChanW-1:0]   bright;
  logic [ChanW-1:0]   bright_next;
  logic signed [30:0] d_ext;
  logic signed [30:0] c2_ext;
  logic signed [30:0] prod;
  logic signed [30:0] n;
  logic [ChanW-1:0]   ch_next;

  always_comb begin
    bv = $signed({3'b000, p, 8'h00}) + $signed({{2{offset[OffsetW-1]}}, offset});
    if (bv[18]) begin
      bright_next = '0;
    end else if (bv[17:16] != 2'b00) begin
      bright_next = '1;
    end else begin
      bright_next = bv[15:8];
    end
  end

  always_ff @(posedge clk) begin
    bright <= bright_next;
  end

  always_comb begin
    d_ext  = $signed({22'd0, bright, 1'b0}) - 31'sd255;
    c2_ext = $signed({11'd0, c2});
    prod   = 31'(d_ext * c2_ext);
    n      = prod + 31'sd16711680;
    if (n[30]) begin
      ch_next = '0;
    end else if (n[29:25] != 5'd0) begin
      ch_next = '1;
    end else begin
      ch_next = n[24:17];
    end
  end

  always_ff @(posedge clk) begin
    ch <= ch_next;
  end

endmodule

/* rtl/core/bcs_merge.sv */
// Merging stage: BT.601 luma from the three lanes, then saturation per channel.
// Two register stages with their own valid bits. Depends on bcs_pkg.
module bcs_merge
  import bcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  input  logic             frame_end,
  input  logic [GainW-1:0] sat_gain,
  output result_t          result,
  output logic             done
);

  logic             valid_a;
  logic [LumaW-1:0] g16;
  logic [ChanW-1:0] ch_a [3];
  logic             frame_end_a;
  logic [ChanW-1:0] sat [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_a <= valid;
      done    <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    g16 <= LumaW'(red) * LumaW'(LUMA_WR) + LumaW'(green) * LumaW'(LUMA_WG)
         + LumaW'(blue) * LumaW'(LUMA_WB);
    ch_a[0]     <= red;
    ch_a[1]     <= green;
    ch_a[2]     <= blue;
    frame_end_a <= frame_end;
  end

  always_comb begin
    logic signed [36:0] diff;
    logic signed [36:0] prod;
    logic signed [36:0] n;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({13'd0, ch_a[i], 16'h0000}) - $signed({13'd0, g16});
      prod = 37'(diff * $signed({27'd0, sat_gain}));
      n    = prod + $signed({5'd0, g16, 8'h00});
      if (n[36]) begin
        sat[i] = '0;
      end else if (n[35:32] != 4'd0) begin
        sat[i] = '1;
      end else begin
        sat[i] = n[31:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.red_out       <= sat[0];
    result.green_out     <= sat[1];
    result.blue_out      <= sat[2];
    result.frame_end_out <= frame_end_a;
  end

endmodule
